// ===== src/modem7_filename_sender_defines.svh =====
// modem7_filename_sender_defines.svh: assertion macros for the filename sender
// used by msf_core and msf_out_q; relies on clk and rst_n in the including module
`ifndef MODEM7_FILENAME_SENDER_DEFINES_SVH
`define MODEM7_FILENAME_SENDER_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define MSF_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked on every clock edge out of reset
`define MSF_CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/msf_pkg.sv =====
// msf_pkg: types, codes and name helpers for the modem7 filename sender
// no dependencies; imported by every module of the block
package msf_pkg;

    localparam int NAME_LENGTH = 11;

    // line characters
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_SUB   = 8'h1A;
    localparam logic [7:0] CH_RETRY = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // input operations
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;

    // status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_NAME_ERR = 3'd2;
    localparam logic [2:0] ST_CARRIER  = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_NAME_FIRST = 2'd0;
    localparam logic [1:0] REG_NAME_LAST  = 2'd1;
    localparam logic [1:0] REG_RETRY_LIM  = 2'd2;

    typedef struct packed {
        logic [63:0] name_first_eight;
        logic [23:0] name_last_three;
        logic [7:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
        logic       last;
    } res_t;

    typedef struct packed {
        logic valid;
        logic two;
        res_t first;
        res_t second;
    } push_t;

    // character idx of the name, upper-cased; indexes past the name read as space
    function automatic logic [7:0] name_char(input logic [63:0] first8,
                                             input logic [23:0] last3,
                                             input logic [3:0]  idx);
        logic [127:0] all;
        logic [7:0]   c;
        all = {{5{CH_SPACE}}, last3, first8};
        c = all[{idx, 3'b000} +: 8];
        if (c >= 8'h61 && c <= 8'h7A)
            c = c - 8'h20;
        return c;
    endfunction

    // 0x1A plus all eleven characters, mod 256, as a balanced adder tree
    function automatic logic [7:0] name_sum(input logic [63:0] first8,
                                            input logic [23:0] last3);
        logic [7:0] c [NAME_LENGTH];
        logic [7:0] a0, a1, a2, a3, a4, a5;
        for (int i = 0; i < NAME_LENGTH; i++)
            c[i] = name_char(first8, last3, 4'(i));
        a0 = c[0] + c[1];
        a1 = c[2] + c[3];
        a2 = c[4] + c[5];
        a3 = c[6] + c[7];
        a4 = c[8] + c[9];
        a5 = c[10] + CH_SUB;
        return (a0 + a1) + (a2 + a3) + (a4 + a5);
    endfunction

endpackage

// ===== src/modem7_filename_sender.sv =====
// modem7_filename_sender: top level of the modem7 filename sender
// depends on msf_pkg, msf_cfg, msf_core and msf_out_q
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tuser: op; tdata: rx_byte, carrier
//  m_axis   | out       | tdata: tx_valid, tx_byte, status; tlast: last
//  cfg      | in        | cfg_index selects register, cfg_data its value
//
// one input beat per cycle while the queue has room; a beat passes the input register
// and its results then enter a four-entry result queue, so a result leaves only after
// its beat has passed both registers
// every beat waits in the input register until the queue has two free slots,
// as a beat that answers nak gives two results; a full queue stalls the input
// reset clears state and queue at once, no clearing pass; cfg_ready is always high
module modem7_filename_sender (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte [7:0], carrier [8], zero [15:9]
    input  logic [1:0]  s_axis_tuser,   // op [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // tx_valid [0], tx_byte [8:1], status [11:9], zero
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import msf_pkg::*;

    cfg_t  cfg;
    push_t push;
    res_t  out_res;
    logic  room;

    msf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_rx    (s_axis_tdata[7:0]),
        .in_car   (s_axis_tdata[8]),
        .q_room   (room),
        .push     (push)
    );

    msf_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {4'b0000, out_res.status, out_res.tx_byte, out_res.tx_valid};
    assign m_axis_tlast = out_res.last;

endmodule

// ===== src/msf_cfg.sv =====
// msf_cfg: configuration registers of the filename sender (name and retry limit)
// depends on msf_pkg
module msf_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [63:0]    cfg_data,
    output msf_pkg::cfg_t  cfg
);
    import msf_pkg::*;

    logic [63:0] first_reg;
    logic [23:0] last_reg;
    logic [7:0]  limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= {8{CH_SPACE}};
            last_reg  <= {3{CH_SPACE}};
            limit_reg <= 8'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NAME_FIRST: first_reg <= cfg_data;
                REG_NAME_LAST:  last_reg  <= cfg_data[23:0];
                REG_RETRY_LIM:  limit_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    assign cfg.name_first_eight = first_reg;
    assign cfg.name_last_three  = last_reg;
    assign cfg.retry_limit      = limit_reg;

endmodule

// ===== src/msf_core.sv =====
// msf_core: input register and exchange state machine of the filename sender
// depends on msf_pkg and modem7_filename_sender_defines.svh
`include "modem7_filename_sender_defines.svh"

module msf_core (
    input  logic           clk,
    input  logic           rst_n,
    input  msf_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     in_op,
    input  logic [7:0]     in_rx,
    input  logic           in_car,
    input  logic           q_room,
    output msf_pkg::push_t push
);
    import msf_pkg::*;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_NAK  = 2'd1;
    localparam logic [1:0] PH_WAIT_ACK  = 2'd2;
    localparam logic [1:0] PH_WAIT_CKSM = 2'd3;

    logic       hold_reg;
    logic [1:0] op_reg;
    logic [7:0] rx_reg;
    logic       car_reg;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] rc_reg, rc_next;
    logic [3:0] ci_reg, ci_next;
    logic [7:0] ck_reg, ck_next;

    logic       fire;
    logic       got_byte;
    logic [7:0] rc_inc;
    logic       limit_hit;
    logic [2:0] retry_status;
    logic [1:0] retry_phase;

    assign fire     = hold_reg && q_room;
    assign in_ready = !hold_reg || fire;
    assign got_byte = (op_reg == OP_BYTE);

    // input register: one beat held until the result queue has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else if (in_ready)
            hold_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= in_op;
            rx_reg  <= in_rx;
            car_reg <= in_car;
        end
    end

    // failed attempt: saturating count, compared against the limit
    assign rc_inc       = (rc_reg != 8'hFF) ? rc_reg + 8'd1 : rc_reg;
    assign limit_hit    = (rc_inc >= cfg.retry_limit);
    assign retry_status = limit_hit ? ST_NAME_ERR : ST_BUSY;
    assign retry_phase  = limit_hit ? PH_IDLE : PH_WAIT_NAK;

    always_comb
    begin
        phase_next = phase_reg;
        rc_next    = rc_reg;
        ci_next    = ci_reg;
        ck_next    = ck_reg;
        push.valid  = fire;
        push.two    = 1'b0;
        push.first  = '{tx_valid: 1'b0, tx_byte: 8'h00, status: ST_IDLE, last: 1'b1};
        push.second = '{tx_valid: 1'b1, tx_byte: 8'h00, status: ST_BUSY, last: 1'b1};
        if (fire)
        begin
            if (op_reg == OP_START)
            begin
                rc_next = 8'd0;
                ci_next = 4'd0;
                ck_next = name_sum(cfg.name_first_eight, cfg.name_last_three);
                if (cfg.retry_limit == 8'd0)
                begin
                    phase_next = PH_IDLE;
                    push.first.status = ST_NAME_ERR;
                end
                else if (!car_reg)
                begin
                    phase_next = PH_IDLE;
                    push.first.status = ST_CARRIER;
                end
                else
                begin
                    phase_next = PH_WAIT_NAK;
                    push.first.status = ST_BUSY;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                push.first.status = ST_IDLE;
            end
            else if (!car_reg)
            begin
                phase_next = PH_IDLE;
                push.first.status = ST_CARRIER;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAIT_NAK:
                    begin
                        if (got_byte && rx_reg == CH_NAK)
                        begin
                            push.two = 1'b1;
                            push.first = '{tx_valid: 1'b1, tx_byte: CH_ACK,
                                           status: ST_BUSY, last: 1'b0};
                            push.second.tx_byte = name_char(cfg.name_first_eight,
                                                            cfg.name_last_three, 4'd0);
                            ci_next    = 4'd1;
                            phase_next = PH_WAIT_ACK;
                        end
                        else
                        begin
                            rc_next    = rc_inc;
                            phase_next = retry_phase;
                            push.first.status = retry_status;
                        end
                    end
                    PH_WAIT_ACK:
                    begin
                        push.first.tx_valid = 1'b1;
                        if (got_byte && rx_reg == CH_ACK)
                        begin
                            push.first.status = ST_BUSY;
                            if (ci_reg >= 4'(NAME_LENGTH))
                            begin
                                phase_next = PH_WAIT_CKSM;
                                push.first.tx_byte = CH_SUB;
                            end
                            else
                            begin
                                push.first.tx_byte = name_char(cfg.name_first_eight,
                                                               cfg.name_last_three, ci_reg);
                                ci_next = ci_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            rc_next    = rc_inc;
                            phase_next = retry_phase;
                            push.first.tx_byte = CH_RETRY;
                            push.first.status  = retry_status;
                        end
                    end
                    PH_WAIT_CKSM:
                    begin
                        push.first.tx_valid = 1'b1;
                        if (got_byte && rx_reg == ck_reg)
                        begin
                            phase_next = PH_IDLE;
                            push.first.tx_byte = CH_ACK;
                            push.first.status  = ST_OK;
                        end
                        else
                        begin
                            rc_next    = rc_inc;
                            phase_next = retry_phase;
                            push.first.tx_byte = CH_RETRY;
                            push.first.status  = retry_status;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rc_reg    <= 8'd0;
            ci_reg    <= 4'd0;
            ck_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            rc_reg    <= rc_next;
            ci_reg    <= ci_next;
            ck_reg    <= ck_next;
        end
    end

    `MSF_CHECK_IMP(a_two_only_on_nak, push.two, phase_reg == PH_WAIT_NAK, "pair outside nak wait")
    `MSF_CHECK(a_index_in_name, ci_reg <= 4'(NAME_LENGTH), "character index beyond name")

endmodule

// ===== src/msf_out_q.sv =====
// msf_out_q: four-entry result queue feeding the output stream
// depends on msf_pkg and modem7_filename_sender_defines.svh
`include "modem7_filename_sender_defines.svh"

module msf_out_q (
    input  logic           clk,
    input  logic           rst_n,
    input  msf_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output msf_pkg::res_t  out_res
);
    import msf_pkg::*;

    res_t       mem [4];
    logic [2:0] count_reg, count_next;
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [1:0] push_n;
    logic       pop;

    // room for a two-result item
    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_res   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign push_n    = push.valid ? (push.two ? 2'd2 : 2'd1) : 2'd0;

    assign count_next = count_reg + {1'b0, push_n} - {2'b00, pop};
    assign rd_next    = rd_reg + {1'b0, pop};
    assign wr_next    = wr_reg + push_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            rd_reg    <= 2'd0;
            wr_reg    <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_reg] <= push.first;
        if (push.valid && push.two)
            mem[wr_reg + 2'd1] <= push.second;
    end

    `MSF_CHECK(a_count_bound, count_reg <= 3'd4, "result queue count overflow")
    `MSF_CHECK_IMP(a_push_has_room, push.valid, count_reg <= 3'd2, "push into a full result queue")

endmodule

// ===== test/modem7_filename_sender_tb.sv =====
// modem7_filename_sender_tb: self-checking bench for the modem7 filename sender
// needs msf_pkg and the block's rtl; predicts each reply beat and checks it as it leaves
import msf_pkg::*;

typedef enum logic [1:0] {LINK_IDLE, AWAIT_NAK, AWAIT_ACK, AWAIT_SUM} link_phase_t;

// reply predictor and store of reply beats still to come
class sender_reply_board;
    logic [63:0] name_lo;
    logic [23:0] name_hi;
    logic [7:0]  retry_lim;
    link_phase_t phase;
    logic [7:0]  retries;
    logic [3:0]  next_char;
    logic [7:0]  latched_sum;
    res_t        expected_replies[$];
    int          errors;
    int          checked;
    int          successes;
    int          give_ups;

    function new();
        name_lo     = {8{CH_SPACE}};
        name_hi     = {3{CH_SPACE}};
        retry_lim   = 8'd10;
        phase       = LINK_IDLE;
        retries     = '0;
        next_char   = '0;
        latched_sum = '0;
        errors      = 0;
        checked     = 0;
        successes   = 0;
        give_ups    = 0;
    endfunction

    function int pending();
        return expected_replies.size();
    endfunction

    function void note_reg_write(logic [1:0] idx, logic [63:0] val);
        case (idx)
            REG_NAME_FIRST: name_lo = val;
            REG_NAME_LAST:  name_hi = val[23:0];
            REG_RETRY_LIM:  retry_lim = val[7:0];
            default: ;
        endcase
    endfunction

    // name character as it goes on the line, lower case folded to upper
    function logic [7:0] name_byte(int idx);
        logic [7:0] c;
        if (idx < 8)
            c = name_lo[8*idx +: 8];
        else if (idx < NAME_LENGTH)
            c = name_hi[8*(idx-8) +: 8];
        else
            c = CH_SPACE;
        if (c >= "a" && c <= "z")
            c = c - 8'h20;
        return c;
    endfunction

    function void add_reply(bit v, logic [7:0] b, logic [2:0] s, bit l);
        res_t r;
        r.tx_valid = v;
        r.tx_byte  = b;
        r.status   = s;
        r.last     = l;
        expected_replies.push_back(r);
        if (s == ST_OK)
            successes++;
        if (s == ST_NAME_ERR)
            give_ups++;
    endfunction

    // one more failed attempt; gives up once the limit is reached
    function logic [2:0] fail_attempt();
        if (retries != 8'hFF)
            retries++;
        if (retries >= retry_lim)
        begin
            phase = LINK_IDLE;
            return ST_NAME_ERR;
        end
        phase = AWAIT_NAK;
        return ST_BUSY;
    endfunction

    function void note_rx_beat(logic [1:0] op, logic [7:0] rx, logic car);
        logic [7:0] sum;
        bit         got;
        got = (op == OP_BYTE);
        if (op == OP_START)
        begin
            retries   = '0;
            next_char = '0;
            sum = CH_SUB;
            for (int i = 0; i < NAME_LENGTH; i++)
                sum = sum + name_byte(i);
            latched_sum = sum;
            if (retry_lim == 8'd0)
            begin
                phase = LINK_IDLE;
                add_reply(0, 8'h00, ST_NAME_ERR, 1);
            end
            else if (!car)
            begin
                phase = LINK_IDLE;
                add_reply(0, 8'h00, ST_CARRIER, 1);
            end
            else
            begin
                phase = AWAIT_NAK;
                add_reply(0, 8'h00, ST_BUSY, 1);
            end
            return;
        end
        if (phase == LINK_IDLE)
        begin
            add_reply(0, 8'h00, ST_IDLE, 1);
            return;
        end
        if (!car)
        begin
            phase = LINK_IDLE;
            add_reply(0, 8'h00, ST_CARRIER, 1);
            return;
        end
        case (phase)
            AWAIT_NAK:
                if (got && rx == CH_NAK)
                begin
                    add_reply(1, CH_ACK, ST_BUSY, 0);
                    add_reply(1, name_byte(0), ST_BUSY, 1);
                    next_char = 4'd1;
                    phase = AWAIT_ACK;
                end
                else
                    add_reply(0, 8'h00, fail_attempt(), 1);
            AWAIT_ACK:
                if (got && rx == CH_ACK)
                begin
                    if (next_char >= NAME_LENGTH)
                    begin
                        phase = AWAIT_SUM;
                        add_reply(1, CH_SUB, ST_BUSY, 1);
                    end
                    else
                    begin
                        add_reply(1, name_byte(next_char), ST_BUSY, 1);
                        next_char = next_char + 4'd1;
                    end
                end
                else
                    add_reply(1, CH_RETRY, fail_attempt(), 1);
            default:
                if (got && rx == latched_sum)
                begin
                    phase = LINK_IDLE;
                    add_reply(1, CH_ACK, ST_OK, 1);
                end
                else
                    add_reply(1, CH_RETRY, fail_attempt(), 1);
        endcase
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_tx_beat(logic [15:0] data, logic tl);
        res_t want;
        checked++;
        if (expected_replies.size() == 0)
        begin
            report($sformatf("beat %h arrived with nothing expected", data));
            return;
        end
        want = expected_replies.pop_front();
        if (data[0] !== want.tx_valid)
            report($sformatf("tx_valid %b, wanted %b", data[0], want.tx_valid));
        if (data[8:1] !== want.tx_byte)
            report($sformatf("tx_byte %h, wanted %h", data[8:1], want.tx_byte));
        if (data[11:9] !== want.status)
            report($sformatf("status %0d, wanted %0d", data[11:9], want.status));
        if (tl !== want.last)
            report($sformatf("tlast %b, wanted %b", tl, want.last));
    endtask
endclass

module modem7_filename_sender_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    int tx_idle_pct;
    int rx_idle_pct;
    int cycles;
    int n_items;
    int waited;

    sender_reply_board sb;

    modem7_filename_sender DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("FAIL modem7_filename_sender");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_tx_beat(m_axis_tdata, m_axis_tlast);

    task automatic send_item(input logic [1:0] op, input logic [7:0] rx, input logic car);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, car, rx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_rx_beat(op, rx, car);
        n_items++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.note_reg_write(idx, val);
    endtask

    // stop sending and let every reply beat out, plus the queue's latency
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] name_fill();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(8'h61, 8'h7A));
            1: return 8'($urandom);
            2: return 8'($urandom_range(8'h5F, 8'h62));
            3: return CH_SPACE;
            default: return 8'($urandom_range(8'h79, 8'h7C));
        endcase
    endfunction

    task automatic reconfigure(input int k);
        logic [63:0] lo;
        logic [23:0] hi;
        logic [7:0]  lim;
        int          pick;
        if (k == 1)
        begin
            lo  = '0;
            hi  = '1;
            lim = 8'hFF;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
                lo[8*i +: 8] = name_fill();
            for (int i = 0; i < 3; i++)
                hi[8*i +: 8] = name_fill();
            pick = $urandom_range(0, 15);
            if (pick == 0)
                lim = 8'd0;
            else if (pick < 6)
                lim = 8'($urandom_range(1, 3));
            else if (pick < 11)
                lim = 8'($urandom_range(4, 20));
            else if (pick < 15)
                lim = 8'd10;
            else
                lim = 8'hFF;
        end
        write_reg(REG_NAME_FIRST, lo);
        write_reg(REG_NAME_LAST, {40'd0, hi});
        write_reg(REG_RETRY_LIM, {56'd0, lim});
    endtask

    // mostly the start or byte the exchange is waiting for, with noise mixed in
    task automatic random_item();
        logic [1:0] op;
        logic [7:0] rx;
        logic       car;
        int         dice;
        dice = $urandom_range(0, 99);
        op   = 2'($urandom_range(0, 3));
        rx   = 8'($urandom);
        car  = ($urandom_range(0, 99) != 0);
        if (sb.phase == LINK_IDLE)
        begin
            if (dice < 85)
                op = OP_START;
        end
        else if (dice < 82)
        begin
            op = OP_BYTE;
            case (sb.phase)
                AWAIT_NAK: rx = CH_NAK;
                AWAIT_ACK: rx = CH_ACK;
                default:   rx = sb.latched_sum;
            endcase
        end
        send_item(op, rx, car);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_NAME_FIRST;
        cfg_data      = '0;
        cycles        = 0;
        n_items       = 0;
        tx_idle_pct   = 28;
        rx_idle_pct   = 52;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // traffic before any start, with the reset name and limit; then starts with a limit of zero and with no carrier
        send_item(OP_BYTE, CH_ACK, 1'b1);
        send_item(OP_SPARE, 8'h00, 1'b1);
        wait_drained();
        write_reg(REG_NAME_FIRST, '1);
        write_reg(REG_NAME_LAST, '0);
        write_reg(REG_RETRY_LIM, '0);
        send_item(OP_START, 8'h00, 1'b1);
        wait_drained();
        write_reg(REG_RETRY_LIM, 64'd2);
        send_item(OP_START, 8'hFF, 1'b0);
        // clean exchange through to the checksum
        send_item(OP_START, 8'h00, 1'b1);
        send_item(OP_BYTE, CH_NAK, 1'b1);
        repeat (NAME_LENGTH) send_item(OP_BYTE, CH_ACK, 1'b1);
        send_item(OP_BYTE, sb.latched_sum, 1'b1);
        // two failed nak waits use up a limit of two; spare op is a timeout
        send_item(OP_START, 8'h00, 1'b1);
        send_item(OP_TIMEOUT, 8'h00, 1'b1);
        send_item(OP_SPARE, CH_NAK, 1'b1);
        // wrong echo, then the carrier goes
        send_item(OP_START, 8'h00, 1'b1);
        send_item(OP_BYTE, CH_NAK, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_TIMEOUT, 8'h00, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 52 : 0;
            rx_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 28 : 0;
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                reconfigure(ph * 4 + chunk);
                repeat (67) random_item();
                wait_drained();
            end
        end

        waited = 0;
        while (sb.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d reply beats never arrived", sb.pending()));
        $display("sent %0d input beats and checked %0d reply beats", n_items, sb.checked);
        $display("%0d exchanges acknowledged, %0d given up on retries",
                 sb.successes, sb.give_ups);
        if (sb.errors == 0)
            $display("PASS modem7_filename_sender");
        else
            $display("FAIL modem7_filename_sender");
        $finish;
    end
endmodule
